// File: design/rua_pkg.sv
// Package for the rectangle union area block: widths, limits, sequencer states.
// No dependencies; imported by the interfaces, the top level and the testbench.
package rua_pkg;

    localparam int RUA_MAX_RECTS = 16;
    localparam int POS_W         = 15;   // origin coordinate width
    localparam int EXT_W         = 16;   // width / height field width
    localparam int EDGE_W        = 17;   // far edge without wrap
    localparam int AREA_W        = 32;
    localparam int PROD_W        = 2 * EDGE_W;
    localparam int REC_W         = 2 * POS_W + 2 * EXT_W;

    // Sweep sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XRD,
        ST_XGET,
        ST_XSCAN,
        ST_YRD,
        ST_YGET,
        ST_YSCAN,
        ST_CSCAN,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } rua_state_t;

endpackage

// File: design/rua_in_if.sv
// Input channel: one rectangle item per handshake.
// Depends on rua_pkg.
interface rua_in_if
    import rua_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  rect_x;
    logic [POS_W-1:0]  rect_y;
    logic [EXT_W-1:0]  rect_width;
    logic [EXT_W-1:0]  rect_height;
    logic              is_final;

    modport source (output valid, rect_x, rect_y, rect_width, rect_height, is_final,
                    input ready);
    modport sink   (input valid, rect_x, rect_y, rect_width, rect_height, is_final,
                    output ready);
endinterface

// File: design/rua_out_if.sv
// Output channel: one union area item per rectangle set.
// Depends on rua_pkg.
interface rua_out_if
    import rua_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [AREA_W-1:0] union_area;
    logic              dropped;

    modport source (output valid, union_area, dropped, input ready);
    modport sink   (input valid, union_area, dropped, output ready);
endinterface

// File: design/rua_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/rectangle_union_area_top.sv
// Rectangle union area: top level with rectangle store and sweep sequencer.
// Depends on rua_pkg, rua_in_if, rua_out_if, rua_ram.
//
// Usage: rectangles arrive on rect_in, one item per cycle while the block
// is idle, and are written into the rectangle RAM (MAX_RECTS entries).
// Rectangles past the RAM depth are discarded and flagged in dropped.
// The item with is_final set closes the set and starts the sweep; rect_in
// stays not ready until the area item is delivered on area_out.
// The sweep walks every distinct x edge, for each finds the next x edge by
// a RAM scan, then every distinct y edge with its next y edge, and tests
// cell cover by a third scan; all scans go through the one RAM read port at
// one entry per cycle.
// The area item stays on area_out until taken; a stalled receiver holds the
// block idle. Reset clears the count, the drop flag and the output valid;
// the RAM contents are not cleared, only entries below the count are read.
module rectangle_union_area_top
    import rua_pkg::*;
#(
    parameter int MAX_RECTS = RUA_MAX_RECTS
) (
    input  logic      clk,
    input  logic      rst_n,
    rua_in_if.sink    rect_in,
    rua_out_if.source area_out
);
    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = IW + 1;
    localparam int EW = IW + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECTS);

    rua_state_t        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [EW-1:0]     a_reg, a_next;
    logic [EW-1:0]     b_reg, b_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic              pv_reg, pv_next;
    logic [IW-1:0]     pk_reg, pk_next;
    logic [EDGE_W-1:0] e_reg, e_next, nx_reg, nx_next;
    logic [EDGE_W-1:0] ey_reg, ey_next, ny_reg, ny_next;
    logic              nxf_reg, nxf_next, nyf_reg, nyf_next;
    logic              dup_reg, dup_next, cov_reg, cov_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [AREA_W-1:0] acc_reg, acc_next;
    logic              ov_reg, ov_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic              drop_reg, drop_next;

    logic              accept;
    logic              scanning;
    logic              scan_done;
    logic [EW-1:0]     lim;
    logic [EW-1:0]     ei0, ei1;
    logic              we;
    logic [IW-1:0]     raddr;
    logic [REC_W-1:0]  wdata, rdata;
    logic [EDGE_W-1:0] rx0, rx1, ry0, ry1;
    logic              rne;
    logic [AREA_W+2:0] sum;

    // Rectangle store
    assign we    = accept && (cnt_reg < MAX_CNT);
    assign wdata = {rect_in.rect_x, rect_in.rect_y, rect_in.rect_width, rect_in.rect_height};

    rua_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECTS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Decode of the read entry
    assign rx0 = {2'b00, rdata[REC_W-1 -: POS_W]};
    assign ry0 = {2'b00, rdata[REC_W-POS_W-1 -: POS_W]};
    assign rx1 = rx0 + {1'b0, rdata[2*EXT_W-1 -: EXT_W]};
    assign ry1 = ry0 + {1'b0, rdata[EXT_W-1:0]};
    assign rne = (rdata[2*EXT_W-1 -: EXT_W] != '0) && (rdata[EXT_W-1:0] != '0);
    assign ei0 = {1'b0, pk_reg, 1'b0};
    assign ei1 = {1'b0, pk_reg, 1'b1};

    assign accept    = rect_in.valid && rect_in.ready;
    assign lim       = {cnt_reg, 1'b0};
    assign scanning  = state_reg inside {ST_XSCAN, ST_YSCAN, ST_CSCAN};
    assign scan_done = (iss_reg == cnt_reg) && !pv_reg;
    assign sum       = {3'b000, acc_reg} + {1'b0, prod_reg};

    assign rect_in.ready       = (state_reg == ST_IDLE) && !ov_reg;
    assign area_out.valid      = ov_reg;
    assign area_out.union_area = area_reg;
    assign area_out.dropped    = drop_reg;

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        iss_reg  <= iss_next;
        pk_reg   <= pk_next;
        e_reg    <= e_next;
        nx_reg   <= nx_next;
        ey_reg   <= ey_next;
        ny_reg   <= ny_next;
        nxf_reg  <= nxf_next;
        nyf_reg  <= nyf_next;
        dup_reg  <= dup_next;
        cov_reg  <= cov_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        area_reg <= area_next;
        drop_reg <= drop_next;
    end

    // Sweep sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        iss_next   = iss_reg;
        pv_next    = pv_reg;
        pk_next    = pk_reg;
        e_next     = e_reg;
        nx_next    = nx_reg;
        ey_next    = ey_reg;
        ny_next    = ny_reg;
        nxf_next   = nxf_reg;
        nyf_next   = nyf_reg;
        dup_next   = dup_reg;
        cov_next   = cov_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        ov_next    = ov_reg;
        area_next  = area_reg;
        drop_next  = drop_reg;
        raddr      = iss_reg[IW-1:0];

        if (ov_reg && area_out.ready)
        begin
            ov_next = 1'b0;
        end

        // one RAM entry issued per scan cycle
        if (scanning)
        begin
            if (iss_reg < cnt_reg)
            begin
                pv_next  = 1'b1;
                pk_next  = iss_reg[IW-1:0];
                iss_next = iss_reg + 1'b1;
            end
            else
            begin
                pv_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cnt_reg < MAX_CNT)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (rect_in.is_final)
                    begin
                        a_next     = '0;
                        acc_next   = '0;
                        state_next = ST_XRD;
                    end
                end
            end
            ST_XRD:
            begin
                if (a_reg == lim)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    raddr      = a_reg[IW:1];
                    state_next = ST_XGET;
                end
            end
            ST_XGET:
            begin
                e_next = a_reg[0] ? rx1 : rx0;
                if (!rne)
                begin
                    a_next     = a_reg + 1'b1;
                    state_next = ST_XRD;
                end
                else
                begin
                    iss_next   = '0;
                    pv_next    = 1'b0;
                    nxf_next   = 1'b0;
                    dup_next   = 1'b0;
                    state_next = ST_XSCAN;
                end
            end
            ST_XSCAN:
            begin
                // next greater x edge, and whether this edge value came earlier
                if (pv_reg && rne)
                begin
                    if (rx0 > e_reg && (!nxf_next || rx0 < nx_next))
                    begin
                        nx_next  = rx0;
                        nxf_next = 1'b1;
                    end
                    if (rx1 > e_reg && (!nxf_next || rx1 < nx_next))
                    begin
                        nx_next  = rx1;
                        nxf_next = 1'b1;
                    end
                    if ((rx0 == e_reg && ei0 < a_reg) || (rx1 == e_reg && ei1 < a_reg))
                    begin
                        dup_next = 1'b1;
                    end
                end
                if (scan_done)
                begin
                    if (dup_reg || !nxf_reg)
                    begin
                        a_next     = a_reg + 1'b1;
                        state_next = ST_XRD;
                    end
                    else
                    begin
                        b_next     = '0;
                        state_next = ST_YRD;
                    end
                end
            end
            ST_YRD:
            begin
                if (b_reg == lim)
                begin
                    a_next     = a_reg + 1'b1;
                    state_next = ST_XRD;
                end
                else
                begin
                    raddr      = b_reg[IW:1];
                    state_next = ST_YGET;
                end
            end
            ST_YGET:
            begin
                ey_next = b_reg[0] ? ry1 : ry0;
                if (!rne)
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_YRD;
                end
                else
                begin
                    iss_next   = '0;
                    pv_next    = 1'b0;
                    nyf_next   = 1'b0;
                    dup_next   = 1'b0;
                    state_next = ST_YSCAN;
                end
            end
            ST_YSCAN:
            begin
                if (pv_reg && rne)
                begin
                    if (ry0 > ey_reg && (!nyf_next || ry0 < ny_next))
                    begin
                        ny_next  = ry0;
                        nyf_next = 1'b1;
                    end
                    if (ry1 > ey_reg && (!nyf_next || ry1 < ny_next))
                    begin
                        ny_next  = ry1;
                        nyf_next = 1'b1;
                    end
                    if ((ry0 == ey_reg && ei0 < b_reg) || (ry1 == ey_reg && ei1 < b_reg))
                    begin
                        dup_next = 1'b1;
                    end
                end
                if (scan_done)
                begin
                    if (dup_reg || !nyf_reg)
                    begin
                        b_next     = b_reg + 1'b1;
                        state_next = ST_YRD;
                    end
                    else
                    begin
                        iss_next   = '0;
                        pv_next    = 1'b0;
                        cov_next   = 1'b0;
                        state_next = ST_CSCAN;
                    end
                end
            end
            ST_CSCAN:
            begin
                // is the grid cell inside any nonempty rectangle
                if (pv_reg && rne && rx0 <= e_reg && rx1 >= nx_reg
                    && ry0 <= ey_reg && ry1 >= ny_reg)
                begin
                    cov_next = 1'b1;
                end
                if (scan_done)
                begin
                    if (cov_reg)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        b_next     = b_reg + 1'b1;
                        state_next = ST_YRD;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = (nx_reg - e_reg) * (ny_reg - ey_reg);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // saturating accumulate
                acc_next   = (sum[AREA_W+2:AREA_W] != '0) ? '1 : sum[AREA_W-1:0];
                b_next     = b_reg + 1'b1;
                state_next = ST_YRD;
            end
            ST_OUT:
            begin
                ov_next    = 1'b1;
                area_next  = acc_reg;
                drop_next  = ovf_reg;
                cnt_next   = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("rectangle count beyond store depth");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rect_in.ready |-> (state_reg == ST_IDLE && !ov_reg))
        else $error("input ready outside idle");

    a_pv_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (state_reg == ST_XSCAN || state_reg == ST_YSCAN
                    || state_reg == ST_CSCAN))
        else $error("scan data pending outside a scan");

    a_out_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> (cnt_reg == '0 && !ovf_reg && ov_reg))
        else $error("set not closed after result");

    a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !we)
        else $error("store written during sweep");
`endif
endmodule

// File: tb/sv/tb_top.sv
// Testbench for rectangle_union_area_top: directed and random rectangle sets with an area predictor.
// Depends on rua_pkg, rua_in_if, rua_out_if and the design sources.
`timescale 1ns / 1ps

module tb_top;
    import rua_pkg::*;

    typedef struct {
        logic [AREA_W-1:0] area;
        logic              dropped;
    } area_item_t;

    // Keeps its own rectangle store and the queue of expected area items
    class rect_area_board;
        int unsigned x0[RUA_MAX_RECTS], y0[RUA_MAX_RECTS];
        int unsigned x1[RUA_MAX_RECTS], y1[RUA_MAX_RECTS];
        int unsigned count;
        bit          overflow;
        area_item_t  expected_areas[$];
        int          errors;

        function new();
            count    = 0;
            overflow = 0;
            errors   = 0;
        endfunction

        // Covered y length over the slab [xa, xb)
        function longint unsigned slab_len(int unsigned xa, int unsigned xb);
            longint unsigned spans[$];
            longint unsigned span;
            longint unsigned len;
            int unsigned lo, hi, cl, ch;
            len = 0;
            for (int i = 0; i < count; i++)
                if (x1[i] > x0[i] && y1[i] > y0[i] && x0[i] <= xa && x1[i] >= xb) begin
                    span = {32'(y0[i]), 32'(y1[i])};
                    spans.insert(spans.size(), span);
                end
            if (spans.size() == 0)
                return 0;
            spans.sort();
            lo = spans[0][63:32];
            hi = spans[0][31:0];
            for (int i = 1; i < spans.size(); i++) begin
                cl = spans[i][63:32];
                ch = spans[i][31:0];
                if (cl > hi) begin
                    len += 64'(hi - lo);
                    lo = cl;
                    hi = ch;
                end
                else if (ch > hi)
                    hi = ch;
            end
            len += 64'(hi - lo);
            return len;
        endfunction

        function longint unsigned union_area();
            int unsigned edges[$];
            longint unsigned area;
            area = 0;
            for (int i = 0; i < count; i++)
                if (x1[i] > x0[i] && y1[i] > y0[i]) begin
                    edges.insert(edges.size(), x0[i]);
                    edges.insert(edges.size(), x1[i]);
                end
            edges.sort();
            for (int i = 0; i + 1 < edges.size(); i++)
                if (edges[i+1] > edges[i])
                    area += slab_len(edges[i], edges[i+1]) * 64'(edges[i+1] - edges[i]);
            return area;
        endfunction

        function void note_rect(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                logic [EXT_W-1:0] w, logic [EXT_W-1:0] h, logic fin);
            area_item_t e;
            longint unsigned a;
            if (count < RUA_MAX_RECTS) begin
                x0[count] = 32'(x);
                y0[count] = 32'(y);
                x1[count] = 32'(x) + 32'(w);
                y1[count] = 32'(y) + 32'(h);
                count++;
            end
            else
                overflow = 1;
            if (!fin)
                return;
            a = union_area();
            e.area    = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
            e.dropped = overflow;
            expected_areas.insert(expected_areas.size(), e);
            count    = 0;
            overflow = 0;
        endfunction

        function void check_area(logic [AREA_W-1:0] area, logic dropped);
            area_item_t e;
            if (expected_areas.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected area item: area=%0d dropped=%0b", area, dropped);
                return;
            end
            e = expected_areas.pop_front();
            if (e.area !== area || e.dropped !== dropped) begin
                errors++;
                if (errors <= 10)
                    $display("area mismatch: expected area=%0d dropped=%0b, got area=%0d dropped=%0b",
                             e.area, e.dropped, area, dropped);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rua_in_if  rect_in();
    rua_out_if area_out();

    rectangle_union_area_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rect_in  (rect_in.sink),
        .area_out (area_out.source)
    );

    rect_area_board board = new();
    int  accepted_rects = 0;
    bit  sink_hold = 0;
    bit  no_gaps   = 0;
    int  sink_stall = 0;

    initial clk = 0;
    always #10 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Monitor: note accepted rectangles, check delivered areas
    always @(posedge clk) begin
        if (rst_n && rect_in.valid && rect_in.ready) begin
            board.note_rect(rect_in.rect_x, rect_in.rect_y, rect_in.rect_width,
                            rect_in.rect_height, rect_in.is_final);
            accepted_rects++;
        end
        if (rst_n && area_out.valid && area_out.ready)
            board.check_area(area_out.union_area, area_out.dropped);
    end

    // Receiver readiness with random stalls and one long hold-off
    always @(posedge clk) begin
        if (sink_hold)
            area_out.ready <= 1'b0;
        else if (sink_stall > 0) begin
            sink_stall--;
            area_out.ready <= 1'b0;
        end
        else if (no_gaps)
            area_out.ready <= 1'b1;
        else begin
            sink_stall = gap_len();
            area_out.ready <= (sink_stall == 0);
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        wait (accepted_rects >= 300);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (5000) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Offer one rectangle and wait until it is taken
    task automatic send_rect(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [EXT_W-1:0] w, logic [EXT_W-1:0] h, logic fin);
        int g;
        rect_in.valid       <= 1'b1;
        rect_in.rect_x      <= x;
        rect_in.rect_y      <= y;
        rect_in.rect_width  <= w;
        rect_in.rect_height <= h;
        rect_in.is_final    <= fin;
        do
            @(posedge clk);
        while (!rect_in.ready);
        g = no_gaps ? 0 : gap_len();
        if (g > 0) begin
            rect_in.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_random_rect(bit clustered, logic fin);
        logic [POS_W-1:0] x, y;
        logic [EXT_W-1:0] w, h;
        int r;
        if (clustered) begin
            x = POS_W'($urandom_range(0, 200));
            y = POS_W'($urandom_range(0, 200));
        end
        else begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 10)      w = '0;
        else if (r < 60) w = EXT_W'($urandom_range(1, 150));
        else if (r < 85) w = EXT_W'($urandom);
        else             w = 16'(32768 >> $urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 10)      h = '0;
        else if (r < 60) h = EXT_W'($urandom_range(1, 150));
        else if (r < 85) h = EXT_W'($urandom);
        else             h = 16'(32768 >> $urandom_range(0, 15));
        send_rect(x, y, w, h, fin);
    endtask

    initial begin
        int n;
        bit clustered;
        rst_n               <= 1'b0;
        rect_in.valid       <= 1'b0;
        rect_in.rect_x      <= '0;
        rect_in.rect_y      <= '0;
        rect_in.rect_width  <= '0;
        rect_in.rect_height <= '0;
        rect_in.is_final    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single rectangles at the extremes
        send_rect(15'd0, 15'd0, 16'd1, 16'd1, 1'b1);
        send_rect(15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_rect(15'd0, 15'd0, 16'd32768, 16'd32768, 1'b1);
        // empty rectangles only give zero area
        send_rect(15'd100, 15'd100, 16'd0, 16'd50, 1'b0);
        send_rect(15'd100, 15'd100, 16'd50, 16'd0, 1'b1);
        // overlap counted once, nested rectangle, touching edges
        send_rect(15'd0, 15'd0, 16'd10, 16'd10, 1'b0);
        send_rect(15'd5, 15'd5, 16'd10, 16'd10, 1'b0);
        send_rect(15'd2, 15'd2, 16'd3, 16'd3, 1'b0);
        send_rect(15'd15, 15'd0, 16'd5, 16'd5, 1'b1);
        // area past 32 bits saturates
        send_rect(15'd0, 15'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_rect(15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // full store, then the final item itself is dropped
        for (int i = 0; i < RUA_MAX_RECTS + 1; i++)
            send_rect(15'(i * 3), 15'(i * 2), 16'(i + 4), 16'(20 - i), i == RUA_MAX_RECTS);

        // Random sets, mostly small
        while (accepted_rects < 900) begin
            no_gaps = ($urandom_range(0, 9) == 0);
            clustered = $urandom_range(0, 2) != 0;
            n = $urandom_range(0, 99);
            if (n < 90)      n = $urandom_range(1, 6);
            else if (n < 95) n = $urandom_range(7, RUA_MAX_RECTS);
            else             n = $urandom_range(RUA_MAX_RECTS + 1, RUA_MAX_RECTS + 4);
            for (int i = 0; i < n; i++)
                send_random_rect(clustered, i == n - 1);
        end
        rect_in.valid <= 1'b0;
        no_gaps = 0;

        // let the monitor note the last accepted item first
        @(posedge clk);
        while (board.expected_areas.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.expected_areas.size() == 0)
            $display("rectangle_union_area_top regression: pass");
        else
            $display("rectangle_union_area_top regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #400_000_000;
        $display("rectangle_union_area_top regression: fail");
        $finish;
    end
endmodule
